// ----- hw/rtl/contiguous_fit_allocator_core_macros.svh -----
// Assertion helpers used by the allocator core RTL.
`ifndef CONTIGUOUS_FIT_ALLOCATOR_CORE_MACROS_SVH
`define CONTIGUOUS_FIT_ALLOCATOR_CORE_MACROS_SVH

// Check that a condition holds on every clock edge out of reset.
`define CFA_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// Check that a condition in one cycle forces another in the next cycle.
`define CFA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/cfa_pkg.sv -----
`timescale 1ns / 1ps
package cfa_pkg;

    localparam int UNITS = 128;
    localparam int AW    = $clog2(UNITS);
    localparam int UW    = $clog2(UNITS + 1);
    localparam int HW    = $clog2((UNITS + 1) / 2 + 1);
    localparam int CMPW  = (UW > 8) ? UW : 8;

    localparam int ID_W   = 8;
    localparam int SIZE_W = 8;
    localparam int SW_W   = 2;
    localparam int POS_W  = 7;
    localparam int RC_W   = 8;
    localparam int HC_W   = 7;
    localparam int UU_W   = 8;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 56;

    typedef enum logic [1:0] {
        FIT_FIRST = 2'd0,
        FIT_BEST  = 2'd1,
        FIT_NEXT  = 2'd2,
        FIT_WORST = 2'd3
    } fit_mode_t;

    typedef enum logic [1:0] {
        OUT_LOADED    = 2'd0,
        OUT_REQUEUE   = 2'd1,
        OUT_FINISHED  = 2'd2,
        OUT_TOO_LARGE = 2'd3
    } outcome_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_PASS,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [ID_W-1:0] id;
        logic [AW-1:0]   rs;
        logic [AW-1:0]   re;
        logic [SW_W-1:0] swaps;
    } fifo_entry_t;

endpackage

// ----- hw/rtl/cfa_fifo.sv -----
`timescale 1ns / 1ps
module cfa_fifo (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [cfa_pkg::AW-1:0] wr_addr,
    input  cfa_pkg::fifo_entry_t wr_data,
    input  logic [cfa_pkg::AW-1:0] rd_addr,
    output cfa_pkg::fifo_entry_t rd_data
);
    import cfa_pkg::*;

    fifo_entry_t mem [UNITS];
    fifo_entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/contiguous_fit_allocator_core.sv -----
`timescale 1ns / 1ps
// Contiguous fit allocator. Each request transaction (process id, size, swap
// count) is placed into a hole of a 128-unit occupancy map by first, best,
// next or worst fit, chosen by fit_mode; when nothing fits, the oldest
// resident region is evicted and reported instead, and with nothing resident
// the request is reported as too large. One result transaction follows each
// request. One shared compare unit walks the map a unit per cycle to find
// the hole (next fit rescans from unit 0 when nothing fits above its
// position), then a second walk, again a unit per cycle, marks or frees the
// region and counts holes and used units. s_tready is high only between
// requests; a finished result sits in the output register, so the next
// request is taken while it waits. Write fit_mode only while the block is
// idle.
module contiguous_fit_allocator_core (
    input  logic        aclk,
    input  logic        aresetn,
    // fit_mode register
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data,
    // request: [7:0] proc_id, [15:8] req_size, [17:16] swap_count
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [cfa_pkg::IN_DATA_W-1:0]  s_tdata,
    // result: [1:0] outcome, [8:2] region_start, [15:9] region_end,
    // [23:16] victim_id, [25:24] victim_swaps, [33:26] resident_count,
    // [40:34] hole_count, [48:41] used_units
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [cfa_pkg::OUT_DATA_W-1:0] m_tdata
);
    import cfa_pkg::*;

    state_t state_reg, state_next;
    fit_mode_t mode_reg;

    logic [UNITS-1:0] occ_reg, occ_next;
    logic [UW-1:0] u_reg, u_next;
    logic [UW-1:0] run_reg, run_next;
    logic [AW-1:0] start_reg, start_next;
    logic [AW-1:0] pick_reg, pick_next;
    logic [UW-1:0] pick_len_reg, pick_len_next;
    logic pick_ok_reg, pick_ok_next;
    logic rescan_reg, rescan_next;

    logic [ID_W-1:0] id_reg, id_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [SW_W-1:0] sw_reg, sw_next;

    logic [AW-1:0] head_reg, head_next, tail_reg, tail_next, nfp_reg, nfp_next;
    logic [UW-1:0] count_reg, count_next;

    logic [AW-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic act_reg, act_next, val_reg, val_next;
    logic in_hole_reg, in_hole_next;
    logic [HW-1:0] holes_reg, holes_next;
    logic [UW-1:0] used_reg, used_next;

    outcome_t outcome_reg, outcome_next;
    logic [ID_W-1:0] vid_reg, vid_next;
    logic [SW_W-1:0] vsw_reg, vsw_next;

    logic m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic fifo_wr;
    fifo_entry_t fifo_wdata, fifo_rdata;

    // shared compare unit signals
    logic [AW-1:0] idx;
    logic unit_free, run_fits, first_policy, bit_new, in_range;
    logic [SIZE_W-1:0] eff_size;

    cfa_fifo u_fifo (
        .aclk   (aclk),
        .wr_en  (fifo_wr),
        .wr_addr(tail_reg),
        .wr_data(fifo_wdata),
        .rd_addr(head_reg),
        .rd_data(fifo_rdata)
    );

    assign idx = u_reg[AW-1:0];
    assign unit_free = (u_reg < UW'(UNITS)) && !occ_reg[idx];
    assign run_fits = (CMPW'(run_reg) >= CMPW'(size_reg)) && (run_reg != '0);
    assign first_policy = (mode_reg != FIT_BEST) && (mode_reg != FIT_WORST);
    assign in_range = act_reg && (idx >= lo_reg) && (idx <= hi_reg);
    assign bit_new = in_range ? val_reg : occ_reg[idx];
    assign eff_size = (s_tdata[15:8] == '0) ? SIZE_W'(1) : s_tdata[15:8];

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            mode_reg     <= FIT_FIRST;
            occ_reg      <= '0;
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            nfp_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            if (cfg_wr_en) begin
                mode_reg <= fit_mode_t'(cfg_wr_data);
            end
            occ_reg      <= occ_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
            nfp_reg      <= nfp_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        u_reg        <= u_next;
        run_reg      <= run_next;
        start_reg    <= start_next;
        pick_reg     <= pick_next;
        pick_len_reg <= pick_len_next;
        pick_ok_reg  <= pick_ok_next;
        rescan_reg   <= rescan_next;
        id_reg       <= id_next;
        size_reg     <= size_next;
        sw_reg       <= sw_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        act_reg      <= act_next;
        val_reg      <= val_next;
        in_hole_reg  <= in_hole_next;
        holes_reg    <= holes_next;
        used_reg     <= used_next;
        outcome_reg  <= outcome_next;
        vid_reg      <= vid_next;
        vsw_reg      <= vsw_next;
        m_tdata_reg  <= m_tdata_next;
    end

    always_comb begin
        state_next    = state_reg;
        occ_next      = occ_reg;
        u_next        = u_reg;
        run_next      = run_reg;
        start_next    = start_reg;
        pick_next     = pick_reg;
        pick_len_next = pick_len_reg;
        pick_ok_next  = pick_ok_reg;
        rescan_next   = rescan_reg;
        id_next       = id_reg;
        size_next     = size_reg;
        sw_next       = sw_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        nfp_next      = nfp_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        act_next      = act_reg;
        val_next      = val_reg;
        in_hole_next  = in_hole_reg;
        holes_next    = holes_reg;
        used_next     = used_reg;
        outcome_next  = outcome_reg;
        vid_next      = vid_reg;
        vsw_next      = vsw_reg;
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        fifo_wr       = 1'b0;
        fifo_wdata    = '{id: id_reg, rs: pick_reg,
                          re: AW'(pick_reg + AW'(size_reg) - AW'(1)), swaps: sw_reg};

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    id_next      = s_tdata[7:0];
                    size_next    = eff_size;
                    sw_next      = s_tdata[17:16];
                    run_next     = '0;
                    start_next   = '0;
                    pick_ok_next = 1'b0;
                    rescan_next  = 1'b0;
                    u_next       = (mode_reg == FIT_NEXT) ? UW'(nfp_reg) : '0;
                    // oversize never fits: go straight to eviction, or to too large when nothing is resident
                    state_next   = (CMPW'(eff_size) > CMPW'(UNITS)) ? ST_DECIDE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                u_next = u_reg + UW'(1);
                if (unit_free) begin
                    if (run_reg == '0) begin
                        start_next = idx;
                    end
                    run_next = run_reg + UW'(1);
                end else begin
                    run_next = '0;
                    if (run_fits) begin
                        if (first_policy) begin
                            pick_next    = start_reg;
                            pick_ok_next = 1'b1;
                            state_next   = ST_DECIDE;
                        end else if (!pick_ok_reg ||
                                     (mode_reg == FIT_BEST && run_reg < pick_len_reg) ||
                                     (mode_reg == FIT_WORST && run_reg > pick_len_reg)) begin
                            pick_next     = start_reg;
                            pick_len_next = run_reg;
                            pick_ok_next  = 1'b1;
                        end
                    end
                end
                if (u_reg == UW'(UNITS) && !(run_fits && first_policy)) begin
                    // next fit found nothing above the position: rescan from unit 0
                    if (mode_reg == FIT_NEXT && !rescan_reg) begin
                        u_next      = '0;
                        run_next    = '0;
                        rescan_next = 1'b1;
                    end else begin
                        state_next = ST_DECIDE;
                    end
                end
            end
            ST_DECIDE: begin
                if (pick_ok_reg) begin
                    fifo_wr      = 1'b1;
                    lo_next      = pick_reg;
                    hi_next      = fifo_wdata.re;
                    act_next     = 1'b1;
                    val_next     = 1'b1;
                    tail_next    = (tail_reg == AW'(UNITS - 1)) ? '0 : tail_reg + AW'(1);
                    if (count_reg < UW'(UNITS)) begin
                        count_next = count_reg + UW'(1);
                    end
                    nfp_next     = fifo_wdata.re;
                    outcome_next = OUT_LOADED;
                    vid_next     = '0;
                    vsw_next     = '0;
                end else if (count_reg != '0) begin
                    lo_next    = fifo_rdata.rs;
                    hi_next    = fifo_rdata.re;
                    act_next   = 1'b1;
                    val_next   = 1'b0;
                    vid_next   = fifo_rdata.id;
                    head_next  = (head_reg == AW'(UNITS - 1)) ? '0 : head_reg + AW'(1);
                    count_next = count_reg - UW'(1);
                    if (fifo_rdata.swaps >= SW_W'(2)) begin
                        outcome_next = OUT_FINISHED;
                        vsw_next     = SW_W'(3);
                    end else begin
                        outcome_next = OUT_REQUEUE;
                        vsw_next     = fifo_rdata.swaps + SW_W'(1);
                    end
                end else begin
                    lo_next      = '0;
                    hi_next      = '0;
                    act_next     = 1'b0;
                    val_next     = 1'b0;
                    outcome_next = OUT_TOO_LARGE;
                    vid_next     = '0;
                    vsw_next     = '0;
                end
                u_next       = '0;
                in_hole_next = 1'b0;
                holes_next   = '0;
                used_next    = '0;
                state_next   = ST_PASS;
            end
            ST_PASS: begin
                // update one unit and count holes and used units
                occ_next[idx] = bit_new;
                in_hole_next  = !bit_new;
                if (!bit_new && !in_hole_reg) begin
                    holes_next = holes_reg + HW'(1);
                end
                if (bit_new) begin
                    used_next = used_reg + UW'(1);
                end
                u_next = u_reg + UW'(1);
                if (u_reg == UW'(UNITS - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = '0;
                    m_tdata_next[1:0]   = outcome_reg;
                    m_tdata_next[8:2]   = (outcome_reg == OUT_TOO_LARGE) ? '0 : POS_W'(lo_reg);
                    m_tdata_next[15:9]  = (outcome_reg == OUT_TOO_LARGE) ? '0 : POS_W'(hi_reg);
                    m_tdata_next[23:16] = vid_reg;
                    m_tdata_next[25:24] = vsw_reg;
                    m_tdata_next[33:26] = RC_W'(count_reg);
                    m_tdata_next[40:34] = HC_W'(holes_reg);
                    m_tdata_next[48:41] = UU_W'(used_reg);
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

`include "contiguous_fit_allocator_core_macros.svh"

    `CFA_ASSERT_ALWAYS(a_count_bound, count_reg <= UW'(UNITS), "resident count above map size")
    `CFA_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "accepted while busy")
    `CFA_ASSERT_ALWAYS(a_loaded_no_victim,
        !(state_reg == ST_DONE && outcome_reg == OUT_LOADED) || vid_reg == '0,
        "loaded result carries a victim id")

endmodule
